### rtl/sparse_cell_record_map_unit_macros.svh
// Assertion macros for the sparse cell record map unit checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef SPARSE_CELL_RECORD_MAP_UNIT_MACROS_SVH
`define SPARSE_CELL_RECORD_MAP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/scrm_pkg.sv
// Shared constants and types for the sparse cell record map unit.
// No dependencies; used by the top level and its checker.
package scrm_pkg;

    localparam int CELLS         = 4096;
    localparam int ENTRIES       = 256;
    localparam int PAYLOAD_BYTES = 8;
    localparam int VERSION_BITS  = 16;

    // Fixed field widths of the request and result.
    localparam int POS_W     = 12;
    localparam int PAYLOAD_W = 64;
    localparam int LEN_W     = 4;
    localparam int VER_W     = 16;

    // Derived memory geometry.
    localparam int SLOT_AW = $clog2(CELLS);
    localparam int DIDX_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [VER_W-1:0] VER_MASK = VER_W'((64'(1) << VERSION_BITS) - 64'(1));
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        ACT_GET   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [POS_W-1:0]     position;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     length;
        logic [VER_W-1:0]     record_version;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [LEN_W-1:0]     out_length;
        logic [VER_W-1:0]     out_version;
        logic                 status;
        logic [CNT_W-1:0]     stored_count;
    } rsp_t;

    // One entry of the dense record array.
    typedef struct packed {
        logic [POS_W-1:0]     pos;
        logic [PAYLOAD_W-1:0] data;
        logic [LEN_W-1:0]     len;
        logic [VER_W-1:0]     ver;
    } rec_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_FETCH,
        ST_MOVE
    } state_t;

endpackage

### rtl/sparse_cell_record_map_unit.sv
// Sparse-set map from cell positions to fixed-size records.
// Depends on scrm_pkg for constants, request and result types.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_t (action, position, payload, ...)
// result    out        done high for one cycle   rsp_t (hit, out_payload, ..., stored_count)
//
// After reset the slot table is swept to zero, one entry per cycle, with busy high
// until all 4096 entries are cleared and the first request can be taken.
// A get, a clear or a zero-length set that finds a record passes through lookup and
// then a fetch or move state before the next accept (slot read, record read, write
// back); all other requests go back to idle straight from lookup.
// The extra state is needed because the slot and record memories have registered reads.
// The result strobe comes in the cycle after the last step; it cannot be stalled.
module sparse_cell_record_map_unit
    import scrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    // Memories.
    logic [CNT_W-1:0] slot_mem [CELLS];
    rec_t             dense_mem [ENTRIES];

    logic [CNT_W-1:0] slot_rd_reg;
    rec_t             dense_rd_reg;

    // Control and payload registers.
    state_t             state_reg, state_next;
    logic [SLOT_AW-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    req_t               req_reg, req_next;
    logic [DIDX_W-1:0]  idx_reg, idx_next;
    logic               done_reg, done_next;
    rsp_t               result_reg, result_next;

    // Memory port controls.
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [CNT_W-1:0]   slot_wdata;
    logic [SLOT_AW-1:0] slot_raddr;
    logic               dense_we;
    logic [DIDX_W-1:0]  dense_waddr;
    rec_t               dense_wdata;
    logic [DIDX_W-1:0]  dense_raddr;

    // Request clean-up and lookup decode.
    logic [LEN_W-1:0]     len_sat;
    logic [PAYLOAD_W-1:0] data_mask;
    req_t                 req_clean;
    logic                 in_range;
    logic                 found;
    logic [DIDX_W-1:0]    found_idx;
    logic [DIDX_W-1:0]    last_idx;
    logic                 is_remove;
    logic                 is_set;
    rec_t                 new_rec;
    rsp_t                 rsp_base;

    // Saturate the length, zero bytes past it and mask the version.
    always_comb
    begin
        len_sat = (request.length > LEN_MAX) ? LEN_MAX : request.length;
        for (int b = 0; b < PAYLOAD_W / 8; b++)
        begin
            data_mask[b*8 +: 8] = (b < int'(len_sat)) ? request.payload[b*8 +: 8] : 8'h00;
        end
        req_clean                = request;
        req_clean.payload        = data_mask;
        req_clean.length         = len_sat;
        req_clean.record_version = request.record_version & VER_MASK;
    end

    // Decode the slot that was read for the held request.
    always_comb
    begin
        in_range  = int'(req_reg.position) < CELLS;
        found     = in_range && (slot_rd_reg != '0) && (slot_rd_reg <= count_reg)
                    && (int'(slot_rd_reg) <= ENTRIES);
        found_idx = DIDX_W'(slot_rd_reg - CNT_W'(1));
        last_idx  = DIDX_W'(count_reg - CNT_W'(1));
        is_remove = (req_reg.action == ACT_CLEAR)
                    || ((req_reg.action == ACT_SET) && (req_reg.length == '0));
        is_set    = (req_reg.action == ACT_SET) && (req_reg.length != '0);

        new_rec.pos  = req_reg.position;
        new_rec.data = req_reg.payload;
        new_rec.len  = req_reg.length;
        new_rec.ver  = req_reg.record_version;

        rsp_base              = '0;
        rsp_base.hit          = found;
        rsp_base.stored_count = count_reg;
    end

    // Next state, memory accesses and result.
    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        slot_we     = 1'b0;
        slot_waddr  = sweep_reg;
        slot_wdata  = '0;
        slot_raddr  = SLOT_AW'(request.position);
        dense_we    = 1'b0;
        dense_waddr = idx_reg;
        dense_wdata = dense_rd_reg;
        dense_raddr = last_idx;

        unique case (state_reg)
            ST_SWEEP:
            begin
                slot_we    = 1'b1;
                slot_waddr = sweep_reg;
                sweep_next = sweep_reg + SLOT_AW'(1);
                if (sweep_reg == SLOT_AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_clean;
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                idx_next    = found_idx;
                result_next = rsp_base;
                priority if (req_reg.action == ACT_GET)
                begin
                    if (found)
                    begin
                        dense_raddr = found_idx;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (is_remove)
                begin
                    if (found)
                    begin
                        // Free the slot now; the last record is read for the move.
                        slot_we     = 1'b1;
                        slot_waddr  = SLOT_AW'(req_reg.position);
                        slot_wdata  = '0;
                        dense_raddr = last_idx;
                        state_next  = ST_MOVE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (is_set && in_range)
                begin
                    if (found)
                    begin
                        dense_we    = 1'b1;
                        dense_waddr = found_idx;
                        dense_wdata = new_rec;
                    end
                    else if (int'(count_reg) >= ENTRIES)
                    begin
                        result_next.status = 1'b1;
                    end
                    else
                    begin
                        // Append at the end of the dense array.
                        dense_we                 = 1'b1;
                        dense_waddr              = DIDX_W'(count_reg);
                        dense_wdata              = new_rec;
                        slot_we                  = 1'b1;
                        slot_waddr               = SLOT_AW'(req_reg.position);
                        slot_wdata               = count_reg + CNT_W'(1);
                        count_next               = count_reg + CNT_W'(1);
                        result_next.stored_count = count_reg + CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FETCH:
            begin
                result_next.hit          = 1'b1;
                result_next.out_payload  = dense_rd_reg.data;
                result_next.out_length   = dense_rd_reg.len;
                result_next.out_version  = dense_rd_reg.ver;
                result_next.status       = 1'b0;
                result_next.stored_count = count_reg;
                done_next                = 1'b1;
                state_next               = ST_IDLE;
            end

            ST_MOVE:
            begin
                // Move the last record into the hole and re-point its slot.
                dense_we    = 1'b1;
                dense_waddr = idx_reg;
                dense_wdata = dense_rd_reg;
                if (idx_reg != last_idx)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = SLOT_AW'(dense_rd_reg.pos);
                    slot_wdata = CNT_W'(idx_reg) + CNT_W'(1);
                end
                count_next               = count_reg - CNT_W'(1);
                result_next              = '0;
                result_next.hit          = 1'b1;
                result_next.stored_count = count_reg - CNT_W'(1);
                done_next                = 1'b1;
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    // Slot table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    // Dense record array: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
        dense_rd_reg <= dense_mem[dense_raddr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/scrm_checker.sv
// Port-level checks for the sparse cell record map unit, bound to the top level.
// Depends on scrm_pkg and sparse_cell_record_map_unit_macros.svh.
`include "sparse_cell_record_map_unit_macros.svh"

module scrm_checker
    import scrm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result
);

    // A result is only shown once the unit is free again.
    `SCRM_ASSERT_SAME(a_done_not_busy, done, !busy)

    // A result always follows a cycle of work.
    `SCRM_ASSERT_SAME(a_done_after_busy, done, $past(busy))

    // An accepted request makes the unit busy.
    `SCRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // The record count never exceeds the dense array.
    `SCRM_ASSERT_SAME(a_count_bound, done, int'(result.stored_count) <= ENTRIES)

    // A refused set only happens on a miss with the array full.
    `SCRM_ASSERT_SAME(a_full_refuse, done && result.status,
                      !result.hit && (int'(result.stored_count) == ENTRIES))

endmodule

bind sparse_cell_record_map_unit scrm_checker u_scrm_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sparse cell record map unit.
// Depends on scrm_pkg and the RTL top level; directed rows, then random requests
// checked against a local predictor of the slot table and dense record array.
module testbench;
    import scrm_pkg::*;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;

    // Predictor state: one-based slot pointers, dense records and their count.
    int   slot_ptr [CELLS];
    rec_t dense_copy [ENTRIES];
    int   record_total;

    rsp_t     awaited_results [$];
    dir_row_t directed_rows [$];
    int       fails;
    bit       quiet;

    sparse_cell_record_map_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Run limit, far above the slowest correct run including the reset sweep.
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Applies one request to the predicted map and returns the result it yields.
    function automatic rsp_t map_update(req_t r);
        rsp_t             res;
        int               s;
        int               idx;
        int               last;
        int               len;
        logic [63:0]      data;
        logic [VER_W-1:0] ver;
        res  = '0;
        len  = r.length;
        if (len > PAYLOAD_BYTES)
            len = PAYLOAD_BYTES;
        data = r.payload;
        if (len < 8)
            data = data & ((64'd1 << (len * 8)) - 64'd1);
        ver  = r.record_version & VER_MASK;
        s    = slot_ptr[r.position];
        idx  = (s == 0 || s > record_total) ? -1 : s - 1;

        if (r.action == ACT_GET)
        begin
            if (idx >= 0)
            begin
                res.out_payload = dense_copy[idx].data;
                res.out_length  = dense_copy[idx].len;
                res.out_version = dense_copy[idx].ver;
            end
        end
        else if (r.action == ACT_CLEAR || (r.action == ACT_SET && len == 0))
        begin
            // Swap-remove: the last record fills the hole and its slot is re-pointed.
            if (idx >= 0)
            begin
                last = record_total - 1;
                dense_copy[idx] = dense_copy[last];
                record_total = last;
                if (idx < last)
                    slot_ptr[dense_copy[idx].pos] = idx + 1;
                slot_ptr[r.position] = 0;
            end
        end
        else if (r.action == ACT_SET)
        begin
            if (idx >= 0)
            begin
                dense_copy[idx].data = data;
                dense_copy[idx].len  = LEN_W'(len);
                dense_copy[idx].ver  = ver;
            end
            else if (record_total >= ENTRIES)
            begin
                res.status = 1'b1;
            end
            else
            begin
                dense_copy[record_total].pos  = r.position;
                dense_copy[record_total].data = data;
                dense_copy[record_total].len  = LEN_W'(len);
                dense_copy[record_total].ver  = ver;
                record_total = record_total + 1;
                slot_ptr[r.position] = record_total;
            end
        end

        res.hit          = (idx >= 0);
        res.stored_count = CNT_W'(record_total);
        return res;
    endfunction

    function automatic rsp_t make_result(bit hit, logic [63:0] pay, int len, int ver,
                                         bit status, int count);
        rsp_t res;
        res.hit          = hit;
        res.out_payload  = pay;
        res.out_length   = LEN_W'(len);
        res.out_version  = VER_W'(ver);
        res.status       = status;
        res.stored_count = CNT_W'(count);
        return res;
    endfunction

    task automatic add_row(action_t a, int pos, logic [63:0] pay, int len, int ver,
                           bit typed, rsp_t want);
        dir_row_t row;
        row.req.action         = a;
        row.req.position       = POS_W'(pos);
        row.req.payload        = pay;
        row.req.length         = LEN_W'(len);
        row.req.record_version = VER_W'(ver);
        row.typed              = typed;
        row.want               = want;
        directed_rows.push_back(row);
    endtask

    // Random request: positions from a pool, with a few anywhere in the table.
    function automatic req_t random_request(int base, int span, int pct_set, int pct_clear);
        req_t r;
        int   roll;
        int   len_roll;
        roll = $urandom_range(0, 99);
        if (roll < pct_set)
            r.action = ACT_SET;
        else if (roll < pct_set + pct_clear)
            r.action = ACT_CLEAR;
        else if (roll < 96)
            r.action = ACT_GET;
        else
            r.action = ACT_NOP;
        if ($urandom_range(0, 19) == 0)
            r.position = POS_W'($urandom_range(0, CELLS - 1));
        else
            r.position = POS_W'((base + $urandom_range(0, span - 1)) % CELLS);
        r.payload = {$urandom, $urandom};
        len_roll  = $urandom_range(0, 9);
        if (len_roll == 0)
            r.length = '0;
        else if (len_roll == 1)
            r.length = LEN_W'($urandom_range(9, 15));
        else
            r.length = LEN_W'($urandom_range(1, 8));
        r.record_version = VER_W'($urandom);
        return r;
    endfunction

    // Drives one request until accepted, records its expected result, then may idle for a random gap (none when quiet).
    task automatic send_request(req_t r, bit typed, rsp_t want);
        rsp_t predicted;
        int   gap;
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = map_update(r);
        awaited_results.push_back(typed ? want : predicted);
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_result(rsp_t got, rsp_t want);
        if (got.hit !== want.hit)
        begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            fails++;
        end
        if (got.out_payload !== want.out_payload)
        begin
            $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
            fails++;
        end
        if (got.out_length !== want.out_length)
        begin
            $error("out_length: expected %0d, got %0d", want.out_length, got.out_length);
            fails++;
        end
        if (got.out_version !== want.out_version)
        begin
            $error("out_version: expected %h, got %h", want.out_version, got.out_version);
            fails++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
        end
        if (got.stored_count !== want.stored_count)
        begin
            $error("stored_count: expected %0d, got %0d", want.stored_count,
                   got.stored_count);
            fails++;
        end
    endtask

    // Result monitor: every strobe is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding");
                fails++;
            end
            else
            begin
                compare_result(result, awaited_results.pop_front());
            end
        end
    end

    // Main sequence.
    initial
    begin
        rsp_t none;
        req_t r;
        int   base;
        int   span;
        int   pct_set;
        int   pct_clear;
        int   count;

        none         = '0;
        fails        = 0;
        quiet        = 1'b0;
        record_total = 0;
        for (int i = 0; i < CELLS; i++)
            slot_ptr[i] = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: extremes, overwrite, saturation, the unused action code,
        // set of length zero, clears of missing records and swap-remove moves.
        add_row(ACT_GET, 0, '0, 0, 0, 1, make_result(0, '0, 0, 0, 0, 0));
        add_row(ACT_SET, 0, '1, 8, 16'hFFFF, 1, make_result(0, '0, 0, 0, 0, 1));
        add_row(ACT_GET, 0, '0, 0, 0, 1, make_result(1, '1, 8, 16'hFFFF, 0, 1));
        add_row(ACT_SET, 4095, 64'h0123456789ABCDEF, 15, 0, 1,
                make_result(0, '0, 0, 0, 0, 2));
        add_row(ACT_GET, 4095, '1, 15, 16'hFFFF, 1,
                make_result(1, 64'h0123456789ABCDEF, 8, 0, 0, 2));
        add_row(ACT_SET, 4095, '1, 3, 16'h1234, 1, make_result(1, '0, 0, 0, 0, 2));
        add_row(ACT_GET, 4095, '0, 0, 0, 1,
                make_result(1, 64'h0000000000FFFFFF, 3, 16'h1234, 0, 2));
        add_row(ACT_NOP, 0, '1, 8, 16'hFFFF, 1, make_result(1, '0, 0, 0, 0, 2));
        add_row(ACT_NOP, 100, '1, 8, 16'hFFFF, 1, make_result(0, '0, 0, 0, 0, 2));
        add_row(ACT_SET, 0, '1, 0, 16'hFFFF, 1, make_result(1, '0, 0, 0, 0, 1));
        add_row(ACT_GET, 0, '0, 0, 0, 1, make_result(0, '0, 0, 0, 0, 1));
        add_row(ACT_CLEAR, 0, '0, 0, 0, 1, make_result(0, '0, 0, 0, 0, 1));
        add_row(ACT_CLEAR, 4095, '0, 0, 0, 1, make_result(1, '0, 0, 0, 0, 0));
        add_row(ACT_SET, 12'h555, 64'hAAAAAAAAAAAAAAAA, 1, 16'h5555, 0, none);
        add_row(ACT_SET, 12'hAAA, 64'h5555555555555555, 8, 16'hAAAA, 0, none);
        add_row(ACT_SET, 7, 64'hDEADBEEFCAFEF00D, 4, 16'h0001, 0, none);
        add_row(ACT_CLEAR, 12'h555, '0, 0, 0, 0, none);
        add_row(ACT_GET, 7, '0, 0, 0, 0, none);
        add_row(ACT_GET, 12'hAAA, '0, 0, 0, 0, none);
        add_row(ACT_CLEAR, 7, '0, 0, 0, 0, none);
        add_row(ACT_GET, 12'hAAA, '0, 0, 0, 0, none);
        add_row(ACT_CLEAR, 12'hAAA, '0, 0, 0, 0, none);
        add_row(ACT_GET, 12'hAAA, '0, 0, 0, 0, none);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want);
        drain_results();

        // Random phases: a small busy pool, a set-heavy fill that reaches the
        // full dense array and its refusals, a clear-heavy drain, then the whole
        // position range.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin base = 2000; span = 16;    pct_set = 40; pct_clear = 25; count = 400; end
                1: begin base = 1000; span = 300;   pct_set = 90; pct_clear = 3;  count = 800; end
                2: begin base = 1000; span = 300;   pct_set = 10; pct_clear = 70; count = 500; end
                default:
                   begin base = 0;    span = CELLS; pct_set = 45; pct_clear = 25; count = 300; end
            endcase
            for (int n = 0; n < count; n++)
            begin
                // Switch between gapped and back-to-back stretches.
                if (n % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                r = random_request(base, span, pct_set, pct_clear);
                send_request(r, 1'b0, none);
            end
            drain_results();
        end

        // Let any stray strobe show up before the verdict.
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/scrm_pkg.sv
rtl/sparse_cell_record_map_unit.sv
rtl/scrm_checker.sv
tb/testbench.sv
